>>> src/multi_channel_led_effect_engine_assert.svh
// Assertion macros for the LED effect engine RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef MULTI_CHANNEL_LED_EFFECT_ENGINE_ASSERT_SVH
`define MULTI_CHANNEL_LED_EFFECT_ENGINE_ASSERT_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define MCLED_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mcled assertion failed");
// Condition that must never be seen outside reset.
`define MCLED_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("mcled forbidden condition seen");
`else
`define MCLED_ASSERT(lbl, clk, rst, prop)
`define MCLED_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

>>> src/mcled_pkg.sv
// Shared constants, codes and types of the LED effect engine.
// Depends on nothing; used by every module of the block.
`default_nettype none

package mcled_pkg;

  localparam int GROUP_A_COUNT = 3;
  localparam int GROUP_B_COUNT = 6;
  localparam int LED_TOTAL     = GROUP_A_COUNT + GROUP_B_COUNT + 1;
  localparam int B_BASE        = GROUP_A_COUNT;
  localparam int LINK_SLOT     = GROUP_A_COUNT + GROUP_B_COUNT;
  localparam int SLOT_W        = $clog2(LED_TOTAL);

  localparam logic [SLOT_W-1:0] B0_SLOT       = SLOT_W'(B_BASE);
  localparam logic [SLOT_W-1:0] LINK_SLOT_IDX = SLOT_W'(LINK_SLOT);
  localparam logic [SLOT_W-1:0] LAST_SLOT     = SLOT_W'(LED_TOTAL - 1);

  // Field widths.
  localparam int GROUP_W = 2;
  localparam int IDX_W   = 3;
  localparam int MODE_W  = 2;
  localparam int DUR_W   = 24;
  localparam int PER_W   = 16;
  localparam int TICK_W  = 10;
  localparam int TIME_W  = 32;

  localparam int IN_BITS    = GROUP_W + IDX_W + MODE_W + DUR_W + PER_W;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = LED_TOTAL + 1;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_BLINK = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TICK_PERIOD   = 8'd1;

  localparam logic [PER_W-1:0]  DEFAULT_BLINK_RESET = 16'd500;
  localparam logic [TICK_W-1:0] TICK_PERIOD_RESET   = 10'd50;

  // Opcodes, groups and effects.
  localparam logic OP_EFFECT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [GROUP_W-1:0] GRP_A    = 2'd0;
  localparam logic [GROUP_W-1:0] GRP_B    = 2'd1;
  localparam logic [GROUP_W-1:0] GRP_LINK = 2'd2;

  localparam logic [MODE_W-1:0] FX_OFF   = 2'd0;
  localparam logic [MODE_W-1:0] FX_ON    = 2'd1;
  localparam logic [MODE_W-1:0] FX_BLINK = 2'd2;
  localparam logic [MODE_W-1:0] FX_TIMED = 2'd3;

  // Command fields, laid out so that a cast of the low tdata bits fills them.
  typedef struct packed {
    logic [PER_W-1:0]   blink_period_ms;
    logic [DUR_W-1:0]   timed_len_ms;
    logic [MODE_W-1:0]  effect_mode;
    logic [IDX_W-1:0]   led_index;
    logic [GROUP_W-1:0] led_group;
  } in_fields_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              accept_cmd;
    logic              accept_tick;
    logic              visit;
    logic [SLOT_W-1:0] slot;
    logic              load_out;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

>>> src/multi_channel_led_effect_engine.sv
// Top level of the multi-channel LED effect engine.
// Depends on mcled_pkg, mcled_ctrl and mcled_datapath.
//
// Usage: each transfer on the s_axis channel is either an effect command
// (s_axis_tuser = 0) that sets one LED, or an update tick (s_axis_tuser = 1)
// that advances the millisecond clock by tick_period_ms and then visits the
// LEDs of group A, group B and the link LED in that order, one per cycle.
// Every input transfer produces exactly one m_axis transfer that carries
// the lit bits of all LEDs and a flag for a rejected command.
// Sequence: an accepted command goes to the result state, which loads the
// result into the output register and returns to idle; only then is the
// next item taken. A tick visits one LED per cycle over all LEDs, then loads
// the result and returns to idle before the next item is taken.
// Stalls: the result sits in an output register. The block accepts and
// works on the next item while it waits, and holds before loading the next
// result until the receiver has taken the previous one.
// Configuration: cfg_ready is always high; register 0 is default_blink_ms and
// register 1 tick_period_ms. User must write only while idle; not enforced.
// Reset: synchronous; the clock returns to zero, every LED is off, endless,
// dark, with the reset default period, and no result is pending.
`default_nettype none

module multi_channel_led_effect_engine (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  // led_group[1:0], led_index[4:2], effect_mode[6:5], timed_len_ms[30:7],
  // blink_period_ms[46:31], zero fill above.
  input  wire logic [mcled_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // opcode[0]
  input  wire logic [0:0]                             s_axis_tuser,
  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  // group_a_leds[2:0], group_b_leds[8:3], link_led[9], rejected[10],
  // zero fill above.
  output logic [mcled_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [mcled_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [mcled_pkg::CFG_DATA_W-1:0]       cfg_data
);

  mcled_pkg::ctl_cmd_t   ctl;
  mcled_pkg::dp_status_t status;
  mcled_pkg::in_fields_t fields;

  // Command fields are taken straight from the accepted input transfer.
  assign fields    = mcled_pkg::in_fields_t'(s_axis_tdata[mcled_pkg::IN_BITS-1:0]);
  assign cfg_ready = 1'b1;

  mcled_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .opcode   (s_axis_tuser[0]),
    .status   (status),
    .ctl      (ctl)
  );

  mcled_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .fields    (fields),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

`default_nettype wire

>>> src/mcled_ctrl.sv
// Controller of the LED effect engine: input handshake, LED visit sequence
// and result hand-off. Depends on mcled_pkg and the assertion macro header.
`default_nettype none

`include "multi_channel_led_effect_engine_assert.svh"

module mcled_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  opcode,
  input  wire mcled_pkg::dp_status_t status,
  output mcled_pkg::ctl_cmd_t        ctl
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_VISIT = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;

  logic [1:0]                   state;
  logic [1:0]                   state_next;
  logic [mcled_pkg::SLOT_W-1:0] slot;
  logic [mcled_pkg::SLOT_W-1:0] slot_next;
  logic                         take;

  assign in_ready = (state == ST_IDLE);
  assign take     = in_valid && in_ready;

  always_comb begin
    ctl.accept_cmd  = take && (opcode == mcled_pkg::OP_EFFECT);
    ctl.accept_tick = take && (opcode == mcled_pkg::OP_TICK);
    ctl.visit       = (state == ST_VISIT);
    ctl.slot        = slot;
    ctl.load_out    = (state == ST_DONE) && !status.out_busy;
  end

  always_comb begin
    state_next = state;
    slot_next  = slot;
    unique case (state)
      ST_IDLE: begin
        if (ctl.accept_tick) begin
          state_next = ST_VISIT;
          slot_next  = '0;
        end else if (ctl.accept_cmd) begin
          state_next = ST_DONE;
        end
      end
      ST_VISIT: begin
        if (slot == mcled_pkg::LAST_SLOT) begin
          state_next = ST_DONE;
        end else begin
          slot_next = slot + 1'b1;
        end
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      slot  <= '0;
    end else begin
      state <= state_next;
      slot  <= slot_next;
    end
  end

  // A tick starts the sweep at the first LED.
  `MCLED_ASSERT(a_tick_starts_sweep, clk, rst,
    ctl.accept_tick |=> (state == ST_VISIT) && (slot == '0))
  // The sweep ends after the last LED and hands over to the result stage.
  `MCLED_ASSERT(a_sweep_ends, clk, rst,
    (state == ST_VISIT) && (slot == mcled_pkg::LAST_SLOT) |=> state == ST_DONE)
  // A result is never loaded over one that the receiver has not taken.
  `MCLED_ASSERT_NEVER(a_no_overwrite, clk, rst, ctl.load_out && status.out_busy)
  // The visit counter never runs past the last LED.
  `MCLED_ASSERT_NEVER(a_slot_range, clk, rst,
    (state == ST_VISIT) && (slot > mcled_pkg::LAST_SLOT))

endmodule

`default_nettype wire

>>> src/mcled_datapath.sv
// Datapath of the LED effect engine: per-LED state, clock, configuration
// registers and the result register. Depends on mcled_pkg.
`default_nettype none

module mcled_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire mcled_pkg::ctl_cmd_t                   ctl,
  input  wire mcled_pkg::in_fields_t                 fields,
  input  wire logic                                  cfg_wr,
  input  wire logic [mcled_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [mcled_pkg::CFG_DATA_W-1:0]      cfg_data,
  output mcled_pkg::dp_status_t                      status,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [mcled_pkg::OUT_TDATA_W-1:0]          out_data
);

  localparam int SW = mcled_pkg::SLOT_W;
  localparam int TW = mcled_pkg::TIME_W;

  logic [mcled_pkg::PER_W-1:0]  default_blink;
  logic [mcled_pkg::TICK_W-1:0] tick_period;
  logic [TW-1:0]                now_ms;

  logic [mcled_pkg::MODE_W-1:0] effect    [mcled_pkg::LED_TOTAL];
  logic [TW-1:0]                end_time  [mcled_pkg::LED_TOTAL];
  logic [mcled_pkg::PER_W-1:0]  period    [mcled_pkg::LED_TOTAL];
  logic [TW-1:0]                last_tog  [mcled_pkg::LED_TOTAL];
  logic [mcled_pkg::LED_TOTAL-1:0] lit;
  logic                         rejected;

  // Command decode.
  logic                         cmd_hit;
  logic [SW-1:0]                cmd_slot;
  logic                         cmd_b_extra;
  logic [TW-1:0]                cmd_end;
  logic [mcled_pkg::PER_W-1:0]  cmd_period;

  // Visit of one LED.
  logic [SW-1:0]                vslot;
  logic                         v_expire;
  logic                         v_toggle;
  logic                         v_b_upper;
  logic                         v_any_b;
  logic [TW-1:0]                v_elapsed;

  always_comb begin
    cmd_hit  = 1'b0;
    cmd_slot = '0;
    priority if (fields.led_group == mcled_pkg::GRP_A &&
                 {1'b0, fields.led_index} <
                 (mcled_pkg::IDX_W + 1)'(mcled_pkg::GROUP_A_COUNT)) begin
      cmd_hit  = 1'b1;
      cmd_slot = SW'(fields.led_index);
    end else if (fields.led_group == mcled_pkg::GRP_B &&
                 {1'b0, fields.led_index} <
                 (mcled_pkg::IDX_W + 1)'(mcled_pkg::GROUP_B_COUNT)) begin
      cmd_hit  = 1'b1;
      cmd_slot = mcled_pkg::B0_SLOT + SW'(fields.led_index);
    end else if (fields.led_group == mcled_pkg::GRP_LINK) begin
      cmd_hit  = 1'b1;
      cmd_slot = mcled_pkg::LINK_SLOT_IDX;
    end else begin
      cmd_hit  = 1'b0;
    end
  end

  assign cmd_b_extra = (fields.led_group == mcled_pkg::GRP_B) && (fields.led_index != '0);
  assign cmd_period  = (fields.blink_period_ms != '0) ? fields.blink_period_ms : default_blink;
  assign cmd_end     = (fields.effect_mode == mcled_pkg::FX_TIMED && fields.timed_len_ms != '0)
                       ? now_ms + TW'(fields.timed_len_ms) : '0;

  assign vslot     = ctl.slot;
  assign v_expire  = (end_time[vslot] != '0) && (now_ms >= end_time[vslot]);
  assign v_elapsed = now_ms - last_tog[vslot];
  assign v_toggle  = !v_expire &&
                     (effect[vslot] == mcled_pkg::FX_BLINK ||
                      effect[vslot] == mcled_pkg::FX_TIMED) &&
                     (v_elapsed >= TW'(period[vslot]));
  assign v_b_upper = (vslot > mcled_pkg::B0_SLOT) && (vslot < mcled_pkg::LINK_SLOT_IDX);

  // Any group B LED from index 1 up that stays active once this LED is off.
  always_comb begin
    v_any_b = 1'b0;
    for (int k = 1; k < mcled_pkg::GROUP_B_COUNT; k++) begin
      if (effect[mcled_pkg::B_BASE + k] != mcled_pkg::FX_OFF &&
          vslot != SW'(mcled_pkg::B_BASE + k)) begin
        v_any_b = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_blink <= mcled_pkg::DEFAULT_BLINK_RESET;
      tick_period   <= mcled_pkg::TICK_PERIOD_RESET;
      now_ms        <= '0;
      lit           <= '0;
      for (int i = 0; i < mcled_pkg::LED_TOTAL; i++) begin
        effect[i]   <= mcled_pkg::FX_OFF;
        end_time[i] <= '0;
        period[i]   <= mcled_pkg::DEFAULT_BLINK_RESET;
        last_tog[i] <= '0;
      end
    end else begin
      if (cfg_wr && cfg_index == mcled_pkg::REG_DEFAULT_BLINK) begin
        default_blink <= cfg_data[mcled_pkg::PER_W-1:0];
      end
      if (cfg_wr && cfg_index == mcled_pkg::REG_TICK_PERIOD) begin
        tick_period <= cfg_data[mcled_pkg::TICK_W-1:0];
      end

      if (ctl.accept_tick) begin
        now_ms <= now_ms + TW'(tick_period);
      end

      if (ctl.accept_cmd && cmd_hit) begin
        effect[cmd_slot]   <= fields.effect_mode;
        period[cmd_slot]   <= cmd_period;
        end_time[cmd_slot] <= cmd_end;
        if (fields.effect_mode == mcled_pkg::FX_ON) begin
          lit[cmd_slot] <= 1'b1;
          if (cmd_b_extra) begin
            effect[mcled_pkg::B0_SLOT] <= mcled_pkg::FX_ON;
            lit[mcled_pkg::B0_SLOT]    <= 1'b1;
          end
        end else if (fields.effect_mode == mcled_pkg::FX_OFF) begin
          lit[cmd_slot] <= 1'b0;
        end
      end

      if (ctl.visit) begin
        if (v_expire) begin
          effect[vslot]   <= mcled_pkg::FX_OFF;
          end_time[vslot] <= '0;
          lit[vslot]      <= 1'b0;
          if (v_b_upper && !v_any_b) begin
            effect[mcled_pkg::B0_SLOT] <= mcled_pkg::FX_OFF;
            lit[mcled_pkg::B0_SLOT]    <= 1'b0;
          end
        end else if (v_toggle) begin
          lit[vslot]      <= !lit[vslot];
          last_tog[vslot] <= now_ms;
        end
      end
    end
  end

  // Result register and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept_tick) begin
      rejected <= 1'b0;
    end else if (ctl.accept_cmd) begin
      rejected <= !cmd_hit;
    end
    if (ctl.load_out) begin
      // The lit vector is already ordered group A, group B, link from bit 0.
      out_data <= mcled_pkg::OUT_TDATA_W'({rejected, lit});
    end
  end

  assign status.out_busy = out_valid && !out_ready;

endmodule

`default_nettype wire
